>>> src/assert_macros.svh
// Assertion macros used by the converter unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> src/tdsmw_pkg.sv
// Package with shared constants and types of the TDS median window converter.
package tdsmw_pkg;
  localparam int SampleW = 10;
  localparam int TempW = 6;
  localparam int PpmW = 16;
  localparam int DefWindowLength = 30;
  localparam logic [TempW-1:0] TempReset = 6'd25;
  localparam logic [PpmW-1:0] PpmMax = 16'hFFFF;
  // Divider request handed from sequencer to the divider.
  typedef struct packed {
    logic        start;
    logic [25:0] dividend;
    logic [6:0]  divisor;
  } div_req_t;
endpackage

>>> src/tdsmw_divider.sv
// Restoring divider, one quotient bit per cycle.
module tdsmw_divider (
  input  logic                clk,
  input  logic                rst,
  input  tdsmw_pkg::div_req_t req,
  output logic                done,
  output logic [25:0]         quotient
);
  logic [25:0] q;
  logic [6:0]  rem;
  logic [6:0]  dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic [7:0]  trial;

  assign trial = {rem, q[25]} - {1'b0, dvs};
  assign quotient = q;

  // Shift in one dividend bit and subtract when it fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 5'd25;
        q <= req.dividend;
        rem <= '0;
        dvs <= req.divisor;
      end else if (busy) begin
        if (trial[7]) begin
          rem <= {rem[5:0], q[25]};
          q <= {q[24:0], 1'b0};
        end else begin
          rem <= trial[6:0];
          q <= {q[24:0], 1'b1};
        end
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 5'd1;
      end
    end
  end
endmodule

>>> src/tds_median_window_converter_unit.sv
// Top level of the TDS median window converter.
// One request is taken, then the block stays busy until its result is delivered.
// The sample is written into the window in the accept cycle. A rank search then
// compares each candidate slot with every window entry in turn. It stops once
// both middle ranks are found. The divider then computes the quotient, and the
// square, the cubic, the polynomial terms and the final scaling use one shared
// multiplier. The result waits in an output register, and the next request is
// taken at the edge after the result is delivered. Window entries not yet
// written read as zero through a flag per entry, so reset needs no clearing
// pass.
`include "assert_macros.svh"
module tds_median_window_converter_unit #(
  parameter int WINDOW_LENGTH = tdsmw_pkg::DefWindowLength
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tdsmw_pkg::TempW-1:0]   water_temp_c,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tdsmw_pkg::SampleW-1:0] adc_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tdsmw_pkg::SampleW-1:0] median_code,
  output logic [tdsmw_pkg::PpmW-1:0]    tds_ppm
);
  localparam int IdxW = $clog2(WINDOW_LENGTH);
  localparam int CntW = $clog2(WINDOW_LENGTH + 1);
  localparam logic [CntW-1:0] LoRank = CntW'((WINDOW_LENGTH - 1) / 2);
  localparam logic [CntW-1:0] HiRank = CntW'(WINDOW_LENGTH / 2);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WINDOW_LENGTH - 1);
  // 2^26 / 25 rounded up; exact division by 25 for every value the scaling sees.
  localparam logic [25:0] RecipBy25 = 26'd2684355;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RANK = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_SQ   = 9'b000001000,
    S_CU   = 9'b000010000,
    S_P1   = 9'b000100000,
    S_P2   = 9'b001000000,
    S_P3   = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state;
  logic [tdsmw_pkg::TempW-1:0] temp;
  logic [tdsmw_pkg::SampleW-1:0] win [WINDOW_LENGTH];
  logic [WINDOW_LENGTH-1:0] written;
  logic [IdxW-1:0] wslot, cand, scan;
  logic [CntW-1:0] less_cnt, le_cnt;
  logic [tdsmw_pkg::SampleW-1:0] cval, sval, lo_val, hi_val;
  logic lo_found, hi_found;
  logic [25:0] cv;
  logic [31:0] v2;
  logic [31:0] v3;
  logic signed [50:0] acc;
  logic [10:0] msum;
  logic [9:0]  med;
  tdsmw_pkg::div_req_t dreq;
  logic ddone;
  logic [25:0] dq;
  logic [25:0] mul_a, mul_b;
  logic [51:0] mul_p;
  logic signed [50:0] term;
  logic [25:0] ppm_wide;

  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign in_stall = (state != S_IDLE) || out_valid;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) temp <= tdsmw_pkg::TempReset;
    else if (cfg_valid && cfg_ready) temp <= water_temp_c;
  end

  // Window entries not yet written read as zero.
  assign cval = written[cand] ? win[cand] : '0;
  assign sval = written[scan] ? win[scan] : '0;

  // Shared multiplier, operands chosen by state.
  always_comb begin
    mul_a = cv;
    mul_b = cv;
    case (state)
      S_CU: mul_b = v2[25:0];
      S_P1: begin mul_a = 26'(v3); mul_b = 26'd13342; end
      S_P2: begin mul_a = 26'(v2); mul_b = 26'd25586; end
      S_P3: mul_b = 26'd85739;
      // The sum is 200 * 2^16 times the result: shift by 19, then divide by 25.
      S_FIN: begin mul_a = acc[44:19]; mul_b = RecipBy25; end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;
  assign term = signed'(51'(mul_p));
  assign msum = {1'b0, lo_val} + {1'b0, hi_val};
  assign med = msum[10:1];
  assign ppm_wide = mul_p[51:26];
  assign dreq.start = (state == S_RANK) && lo_found && hi_found;
  assign dreq.dividend = 26'({10'd0, med} * 26'd16000);
  assign dreq.divisor = 7'(temp) + 7'd25;

  tdsmw_divider u_div (
    .clk(clk), .rst(rst), .req(dreq), .done(ddone), .quotient(dq)
  );

  // Sequencer: rank search, then divide, then square, cube, polynomial and final scaling.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      written <= '0;
      wslot <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            win[wslot] <= adc_sample;
            written[wslot] <= 1'b1;
            wslot <= (wslot == LastIdx) ? '0 : wslot + 1'b1;
            cand <= '0;
            scan <= '0;
            less_cnt <= '0;
            le_cnt <= '0;
            lo_found <= 1'b0;
            hi_found <= 1'b0;
            state <= S_RANK;
          end
        end
        S_RANK: begin
          if (lo_found && hi_found) begin
            state <= S_DIV;
          end else if (scan == LastIdx) begin
            // Candidate covers rank r when less <= r < le.
            if (less_cnt + CntW'(sval < cval) <= LoRank
                && le_cnt + CntW'(sval <= cval) > LoRank) begin
              lo_found <= 1'b1;
              lo_val <= cval;
            end
            if (less_cnt + CntW'(sval < cval) <= HiRank
                && le_cnt + CntW'(sval <= cval) > HiRank) begin
              hi_found <= 1'b1;
              hi_val <= cval;
            end
            scan <= '0;
            less_cnt <= '0;
            le_cnt <= '0;
            cand <= cand + 1'b1;
          end else begin
            scan <= scan + 1'b1;
            less_cnt <= less_cnt + CntW'(sval < cval);
            le_cnt <= le_cnt + CntW'(sval <= cval);
          end
          median_code <= med;
        end
        S_DIV: begin
          if (ddone) begin
            cv <= dq;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          v2 <= 32'(mul_p >> 16);
          state <= S_CU;
        end
        S_CU: begin
          v3 <= 32'(mul_p >> 16);
          state <= S_P1;
        end
        S_P1: begin
          acc <= term;
          state <= S_P2;
        end
        S_P2: begin
          acc <= acc - term;
          state <= S_P3;
        end
        S_P3: begin
          acc <= acc + term;
          state <= S_FIN;
        end
        S_FIN: begin
          if (acc <= 0) tds_ppm <= '0;
          else if (ppm_wide > 26'(tdsmw_pkg::PpmMax)) tds_ppm <= tdsmw_pkg::PpmMax;
          else tds_ppm <= ppm_wide[15:0];
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk, rst, state != S_IDLE, in_stall, "accept while busy")
  `ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && !in_stall, state == S_RANK, "no rank start")
  `ASSERT_NEXT(a_fin_valid, clk, rst, state == S_FIN, out_valid, "result not shown")
endmodule
